// File: rtl/pclc_pkg.sv
// shared widths, types, codes and helpers for the pole-like cluster classifier
package pclc_pkg;

    localparam int COORD_BITS  = 24;
    localparam int COUNT_BITS  = 16;
    localparam int LABEL_BITS  = 6;
    localparam int MASK_BITS   = 64;
    localparam int SIZE_BITS   = 16;
    localparam int BOUND_BITS  = 23;
    localparam int HEIGHT_BITS = 24;
    localparam int POINTS_BITS = 16;
    localparam int VERDICT_BITS = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;

    // common width for magnitude compares, wide enough for every operand
    localparam int CMP_BITS = 33;
    // a passing extent is at most the bound, so squares only need this many bits
    localparam int SQ_BITS  = (COORD_BITS < BOUND_BITS) ? COORD_BITS : BOUND_BITS;
    localparam int SUM_BITS = 2 * BOUND_BITS + 1;

    localparam int MIN_LABEL_HITS = 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        extent_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [SQ_BITS-1:0]           sq_op_t;
    typedef logic [2*SQ_BITS-1:0]         sq_t;
    typedef logic [2*BOUND_BITS-1:0]      bound_sq_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_POINTS      = 2'd0,
        CFG_POLE_LABEL_MASK = 2'd1,
        CFG_MAX_XY_BOUND    = 2'd2,
        CFG_MIN_HEIGHT      = 2'd3
    } cfg_index_t;

    typedef enum logic [VERDICT_BITS-1:0] {
        VERDICT_PASS       = 3'd0,
        VERDICT_FEW_POINTS = 3'd1,
        VERDICT_FEW_LABELS = 3'd2,
        VERDICT_TOO_WIDE   = 3'd3,
        VERDICT_TOO_SHORT  = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]   min_points;
        logic [MASK_BITS-1:0]   pole_label_mask;
        logic [BOUND_BITS-1:0]  max_xy_bound;
        logic [HEIGHT_BITS-1:0] min_height;
    } cfg_t;

    // running statistics of a finished cluster
    typedef struct packed {
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
        count_t point_count;
        count_t label_hits;
    } stats_t;

    function automatic count_t sat_inc(input count_t c);
        count_t top;
        top = '1;
        return (c == top) ? top : count_t'(c + count_t'(1));
    endfunction

    function automatic logic [POINTS_BITS-1:0] shown_points(input count_t c);
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(c);
        if (wide > CMP_BITS'({POINTS_BITS{1'b1}}))
        begin
            return '1;
        end
        return POINTS_BITS'(wide);
    endfunction

endpackage

// File: rtl/pclc_point_if.sv
// point channel: one lidar point per transfer
interface pclc_point_if;
    import pclc_pkg::*;

    logic                  valid;
    logic                  ready;
    coord_t                pos_x;
    coord_t                pos_y;
    coord_t                pos_z;
    logic [LABEL_BITS-1:0] sem_label;
    logic                  last_point;

    modport source (
        output valid, pos_x, pos_y, pos_z, sem_label, last_point,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, sem_label, last_point,
        output ready
    );
endinterface

// File: rtl/pclc_verdict_if.sv
// verdict channel: one classification result per transfer
interface pclc_verdict_if;
    import pclc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    is_pole;
    logic [VERDICT_BITS-1:0] verdict;
    logic [POINTS_BITS-1:0]  cluster_points;

    modport source (
        output valid, is_pole, verdict, cluster_points,
        input  ready
    );

    modport sink (
        input  valid, is_pole, verdict, cluster_points,
        output ready
    );
endinterface

// File: rtl/pole_like_cluster_classifier_unit.sv
// top level of the pole-like cluster classifier: config registers, accumulator, check pipeline
//
//   channel   role    carries                                         transfer when
//   point     sink    pos_x/y/z (s24 Q15.8), sem_label, last_point    valid && ready
//   verdict   source  is_pole, verdict, cluster_points                valid && ready
//   cfg       write   cfg_we, cfg_index, cfg_data                     cfg_we
//
// one point per cycle while point.ready is high; the accumulator updates min/max and counts
// verdict.valid rises after the last point passes the snapshot register (loaded on the edge
// that transfers it), then compares, squares, and planar sum into the verdict register
// rst_n clears config to defaults, starts a fresh cluster and empties the pipeline
// the whole pipeline holds while the verdict register is full and not taken; point.ready
// is low only in that case
module pole_like_cluster_classifier_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    pclc_point_if.sink                          point,
    pclc_verdict_if.source                      verdict,
    input  logic                                cfg_we,
    input  logic [pclc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pclc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pclc_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   advance;
    logic   fire;
    logic   snap_valid;
    stats_t snap;
    logic   res_valid;
    logic   res_is_pole;
    logic [VERDICT_BITS-1:0] res_verdict;
    logic [POINTS_BITS-1:0]  res_points;

    // register writes, each field truncated to its width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_POINTS:      cfg_next.min_points      = cfg_data[SIZE_BITS-1:0];
                CFG_POLE_LABEL_MASK: cfg_next.pole_label_mask = cfg_data[MASK_BITS-1:0];
                CFG_MAX_XY_BOUND:    cfg_next.max_xy_bound    = cfg_data[BOUND_BITS-1:0];
                CFG_MIN_HEIGHT:      cfg_next.min_height      = cfg_data[HEIGHT_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_points      <= SIZE_BITS'(10);
            cfg_reg.pole_label_mask <= '0;
            cfg_reg.max_xy_bound    <= BOUND_BITS'(256);
            cfg_reg.min_height      <= HEIGHT_BITS'(512);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline moves unless a finished verdict is waiting on the sink
    assign advance     = !res_valid || verdict.ready;
    assign point.ready = advance;
    assign fire        = point.valid && advance;

    pclc_accum u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .fire            (fire),
        .pos_x           (point.pos_x),
        .pos_y           (point.pos_y),
        .pos_z           (point.pos_z),
        .sem_label       (point.sem_label),
        .last_point      (point.last_point),
        .pole_label_mask (cfg_reg.pole_label_mask),
        .snap_valid      (snap_valid),
        .snap            (snap)
    );

    pclc_judge u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .snap_valid  (snap_valid),
        .snap        (snap),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res_is_pole (res_is_pole),
        .res_verdict (res_verdict),
        .res_points  (res_points)
    );

    assign verdict.valid          = res_valid;
    assign verdict.is_pole        = res_is_pole;
    assign verdict.verdict        = res_verdict;
    assign verdict.cluster_points = res_points;
endmodule

// File: rtl/pclc_accum.sv
// running min/max per axis and saturating counters, snapshot on the last point
module pclc_accum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            fire,
    input  pclc_pkg::coord_t                pos_x,
    input  pclc_pkg::coord_t                pos_y,
    input  pclc_pkg::coord_t                pos_z,
    input  logic [pclc_pkg::LABEL_BITS-1:0] sem_label,
    input  logic                            last_point,
    input  logic [pclc_pkg::MASK_BITS-1:0]  pole_label_mask,
    output logic                            snap_valid,
    output pclc_pkg::stats_t                snap
);
    import pclc_pkg::*;

    stats_t stats_reg;
    stats_t stats_next;
    logic   first_pending_reg;
    logic   first_pending_next;
    logic   snap_valid_reg;
    logic   snap_valid_next;
    stats_t snap_reg;
    logic   label_hit;

    assign label_hit = pole_label_mask[sem_label];

    always_comb
    begin
        stats_next         = stats_reg;
        first_pending_next = first_pending_reg;
        if (fire)
        begin
            if (first_pending_reg)
            begin
                stats_next.min_x       = pos_x;
                stats_next.max_x       = pos_x;
                stats_next.min_y       = pos_y;
                stats_next.max_y       = pos_y;
                stats_next.min_z       = pos_z;
                stats_next.max_z       = pos_z;
                stats_next.point_count = count_t'(1);
                stats_next.label_hits  = label_hit ? count_t'(1) : '0;
            end
            else
            begin
                if (pos_x < stats_reg.min_x) stats_next.min_x = pos_x;
                if (pos_x > stats_reg.max_x) stats_next.max_x = pos_x;
                if (pos_y < stats_reg.min_y) stats_next.min_y = pos_y;
                if (pos_y > stats_reg.max_y) stats_next.max_y = pos_y;
                if (pos_z < stats_reg.min_z) stats_next.min_z = pos_z;
                if (pos_z > stats_reg.max_z) stats_next.max_z = pos_z;
                stats_next.point_count = sat_inc(stats_reg.point_count);
                if (label_hit)
                begin
                    stats_next.label_hits = sat_inc(stats_reg.label_hits);
                end
            end
            first_pending_next = last_point;
        end
    end

    assign snap_valid_next = fire && last_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg         <= '0;
            first_pending_reg <= 1'b1;
            snap_valid_reg    <= 1'b0;
        end
        else
        begin
            stats_reg         <= stats_next;
            first_pending_reg <= first_pending_next;
            if (advance)
            begin
                snap_valid_reg <= snap_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            snap_reg <= stats_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
endmodule

// File: rtl/pclc_judge.sv
// three-stage check pipeline: extents and compares, squares, planar sum and verdict
module pclc_judge (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             snap_valid,
    input  pclc_pkg::stats_t                 snap,
    input  pclc_pkg::cfg_t                   cfg,
    output logic                             res_valid,
    output logic                             res_is_pole,
    output logic [pclc_pkg::VERDICT_BITS-1:0] res_verdict,
    output logic [pclc_pkg::POINTS_BITS-1:0] res_points
);
    import pclc_pkg::*;

    // stage 2: extents and the direct compares
    extent_t dx;
    extent_t dy;
    extent_t dz;
    logic    few_points;
    logic    few_labels;
    logic    wide_axis;
    logic    short_z;

    logic    s2_valid_reg;
    sq_op_t  s2_dx_reg;
    sq_op_t  s2_dy_reg;
    logic    s2_few_points_reg;
    logic    s2_few_labels_reg;
    logic    s2_wide_axis_reg;
    logic    s2_short_reg;
    logic [POINTS_BITS-1:0] s2_points_reg;

    // stage 3: squares
    logic      s3_valid_reg;
    sq_t       s3_dx_sq_reg;
    sq_t       s3_dy_sq_reg;
    bound_sq_t s3_b_sq_reg;
    logic      s3_few_points_reg;
    logic      s3_few_labels_reg;
    logic      s3_wide_axis_reg;
    logic      s3_short_reg;
    logic [POINTS_BITS-1:0] s3_points_reg;

    // stage 4: planar sum and verdict
    logic [SUM_BITS-1:0] planar_sum;
    logic                wide_planar;
    verdict_t            verdict_next;

    logic                   out_valid_reg;
    verdict_t               out_verdict_reg;
    logic [POINTS_BITS-1:0] out_points_reg;

    always_comb
    begin
        dx = extent_t'(snap.max_x - snap.min_x);
        dy = extent_t'(snap.max_y - snap.min_y);
        dz = extent_t'(snap.max_z - snap.min_z);
        few_points = CMP_BITS'(snap.point_count) <= CMP_BITS'(cfg.min_points);
        few_labels = CMP_BITS'(snap.label_hits) <= CMP_BITS'(MIN_LABEL_HITS);
        wide_axis  = (CMP_BITS'(dx) > CMP_BITS'(cfg.max_xy_bound)) ||
                     (CMP_BITS'(dy) > CMP_BITS'(cfg.max_xy_bound));
        short_z    = CMP_BITS'(dz) <= CMP_BITS'(cfg.min_height);
    end

    always_comb
    begin
        planar_sum  = SUM_BITS'(s3_dx_sq_reg) + SUM_BITS'(s3_dy_sq_reg);
        wide_planar = planar_sum > SUM_BITS'(s3_b_sq_reg);
        if (s3_few_points_reg)
        begin
            verdict_next = VERDICT_FEW_POINTS;
        end
        else if (s3_few_labels_reg)
        begin
            verdict_next = VERDICT_FEW_LABELS;
        end
        else if (s3_wide_axis_reg || wide_planar)
        begin
            verdict_next = VERDICT_TOO_WIDE;
        end
        else if (s3_short_reg)
        begin
            verdict_next = VERDICT_TOO_SHORT;
        end
        else
        begin
            verdict_next = VERDICT_PASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= snap_valid;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_dx_reg         <= sq_op_t'(dx);
            s2_dy_reg         <= sq_op_t'(dy);
            s2_few_points_reg <= few_points;
            s2_few_labels_reg <= few_labels;
            s2_wide_axis_reg  <= wide_axis;
            s2_short_reg      <= short_z;
            s2_points_reg     <= shown_points(snap.point_count);

            s3_dx_sq_reg      <= sq_t'(s2_dx_reg) * sq_t'(s2_dx_reg);
            s3_dy_sq_reg      <= sq_t'(s2_dy_reg) * sq_t'(s2_dy_reg);
            s3_b_sq_reg       <= bound_sq_t'(cfg.max_xy_bound) * bound_sq_t'(cfg.max_xy_bound);
            s3_few_points_reg <= s2_few_points_reg;
            s3_few_labels_reg <= s2_few_labels_reg;
            s3_wide_axis_reg  <= s2_wide_axis_reg;
            s3_short_reg      <= s2_short_reg;
            s3_points_reg     <= s2_points_reg;

            out_verdict_reg   <= verdict_next;
            out_points_reg    <= s3_points_reg;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_is_pole = (out_verdict_reg == VERDICT_PASS);
    assign res_verdict = out_verdict_reg;
    assign res_points  = out_points_reg;
endmodule
